>>> rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared widths, types and helpers of the point to segment distance unit
// ----------------------------------------------------------------------------
`default_nettype none
package psd_pkg;
  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int T_BITS    = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = DIFF_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int LSQ_W     = PROD_W + 1;
  localparam int REM_W     = LSQ_W + 1;
  localparam int P_W       = T_BITS + MAG_W;
  localparam int E_W       = DIFF_W + 1;
  localparam int SQ_W      = 2 * E_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int RT_W      = (D2_W + 1) / 2;
  localparam int SR_W      = 2 * RT_W;
  localparam int RR_W      = RT_W + 2;
  localparam int OUT_W     = COORD_W + 1;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_END,
    MODE_INTERIOR
  } mode_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] rx;
    logic signed [DIFF_W-1:0] ry;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    mode_t                    mode;
  } geo_t;

  // floor(1e-12 * 2^(2f))
  function automatic logic [63:0] tiny_len_sq(input int f);
    logic [63:0] v;
    case (f)
      20: v = 64'd1;
      21: v = 64'd4;
      22: v = 64'd17;
      23: v = 64'd70;
      24: v = 64'd281;
      25: v = 64'd1125;
      26: v = 64'd4503;
      27: v = 64'd18014;
      28: v = 64'd72057;
      29: v = 64'd288230;
      30: v = 64'd1152921;
      31: v = 64'd4611686;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  localparam logic [LSQ_W-1:0] TINY_LSQ = LSQ_W'(tiny_len_sq(FRAC_BITS));

  function automatic logic [MAG_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] u;
    u = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return MAG_W'(u);
  endfunction

  function automatic logic [E_W-1:0] mag_e(input logic signed [E_W-1:0] v);
    return v[E_W-1] ? E_W'(-v) : E_W'(v);
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/psd_prep.sv
// ----------------------------------------------------------------------------
// psd_prep
// differences, squared length, signed dot product and clamp decision
// ----------------------------------------------------------------------------
`default_nettype none
module psd_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [psd_pkg::COORD_W-1:0]  px,
  input  wire logic [psd_pkg::COORD_W-1:0]  py,
  input  wire logic [psd_pkg::COORD_W-1:0]  ax,
  input  wire logic [psd_pkg::COORD_W-1:0]  ay,
  input  wire logic [psd_pkg::COORD_W-1:0]  bx,
  input  wire logic [psd_pkg::COORD_W-1:0]  by,
  output logic                              vld_o,
  output psd_pkg::geo_t                     geo_o,
  output logic [psd_pkg::LSQ_W-1:0]         dot_o,
  output logic [psd_pkg::LSQ_W-1:0]         len_o
);
  import psd_pkg::*;

  logic [3:0] vld_r, vld_nxt;
  logic signed [DIFF_W-1:0] rx1_r, ry1_r, dx1_r, dy1_r;
  logic signed [DIFF_W-1:0] rx2_r, ry2_r, dx2_r, dy2_r;
  logic signed [DIFF_W-1:0] rx3_r, ry3_r, dx3_r, dy3_r;
  logic [PROD_W-1:0] sqx_r, sqy_r, pdx_r, pdy_r;
  logic sx_r, sy_r;
  logic [LSQ_W-1:0] len3_r, pos3_r, neg3_r;
  geo_t geo_r;
  logic [LSQ_W-1:0] dot_r, len_r, dot_nxt;
  mode_t mode_nxt;

  always_comb begin
    vld_nxt = {vld_r[2:0], vld_i};
    dot_nxt = pos3_r - neg3_r;
    if (len3_r > TINY_LSQ && pos3_r > neg3_r) begin
      mode_nxt = (dot_nxt >= len3_r) ? MODE_END : MODE_INTERIOR;
    end else begin
      mode_nxt = MODE_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= $signed({bx[COORD_W-1], bx}) - $signed({ax[COORD_W-1], ax});
      dy1_r <= $signed({by[COORD_W-1], by}) - $signed({ay[COORD_W-1], ay});
      rx1_r <= $signed({px[COORD_W-1], px}) - $signed({ax[COORD_W-1], ax});
      ry1_r <= $signed({py[COORD_W-1], py}) - $signed({ay[COORD_W-1], ay});

      sqx_r <= PROD_W'(mag_d(dx1_r)) * PROD_W'(mag_d(dx1_r));
      sqy_r <= PROD_W'(mag_d(dy1_r)) * PROD_W'(mag_d(dy1_r));
      pdx_r <= PROD_W'(mag_d(rx1_r)) * PROD_W'(mag_d(dx1_r));
      pdy_r <= PROD_W'(mag_d(ry1_r)) * PROD_W'(mag_d(dy1_r));
      sx_r  <= (rx1_r[DIFF_W-1] == dx1_r[DIFF_W-1]);
      sy_r  <= (ry1_r[DIFF_W-1] == dy1_r[DIFF_W-1]);
      {rx2_r, ry2_r, dx2_r, dy2_r} <= {rx1_r, ry1_r, dx1_r, dy1_r};

      len3_r <= LSQ_W'(sqx_r) + LSQ_W'(sqy_r);
      pos3_r <= (sx_r ? LSQ_W'(pdx_r) : '0) + (sy_r ? LSQ_W'(pdy_r) : '0);
      neg3_r <= (sx_r ? '0 : LSQ_W'(pdx_r)) + (sy_r ? '0 : LSQ_W'(pdy_r));
      {rx3_r, ry3_r, dx3_r, dy3_r} <= {rx2_r, ry2_r, dx2_r, dy2_r};

      geo_r.rx   <= rx3_r;
      geo_r.ry   <= ry3_r;
      geo_r.dx   <= dx3_r;
      geo_r.dy   <= dy3_r;
      geo_r.mode <= mode_nxt;
      dot_r      <= dot_nxt;
      len_r      <= len3_r;
    end
  end

  assign vld_o = vld_r[3];
  assign geo_o = geo_r;
  assign dot_o = dot_r;
  assign len_o = len_r;
endmodule
`default_nettype wire

>>> rtl/core/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// restoring divider, one quotient bit per stage, gives t as unsigned Q0.32
// ----------------------------------------------------------------------------
`default_nettype none
module psd_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire psd_pkg::geo_t                geo_i,
  input  wire logic [psd_pkg::LSQ_W-1:0]    dot_i,
  input  wire logic [psd_pkg::LSQ_W-1:0]    len_i,
  output logic                              vld_o,
  output psd_pkg::geo_t                     geo_o,
  output logic [psd_pkg::T_BITS-1:0]        tq_o
);
  import psd_pkg::*;

  logic [T_BITS-1:0] vld_r;
  geo_t              geo_r [T_BITS];
  logic [LSQ_W-1:0]  rem_r [T_BITS];
  logic [LSQ_W-1:0]  len_r [T_BITS];
  logic [T_BITS-1:0] tq_r  [T_BITS];

  for (genvar i = 0; i < T_BITS; i++) begin : g_stage
    logic              v_in;
    geo_t              g_in;
    logic [LSQ_W-1:0]  r_in, l_in;
    logic [T_BITS-1:0] q_in;
    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  r_sub;

    if (i == 0) begin : g_first
      assign v_in = vld_i;
      assign g_in = geo_i;
      assign r_in = dot_i;
      assign l_in = len_i;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign g_in = geo_r[i-1];
      assign r_in = rem_r[i-1];
      assign l_in = len_r[i-1];
      assign q_in = tq_r[i-1];
    end

    assign r2    = {r_in, 1'b0};
    assign r_sub = r2 - REM_W'(l_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        geo_r[i] <= g_in;
        len_r[i] <= l_in;
        if (r2 >= REM_W'(l_in)) begin
          rem_r[i] <= LSQ_W'(r_sub);
          tq_r[i]  <= {q_in[T_BITS-2:0], 1'b1};
        end else begin
          rem_r[i] <= LSQ_W'(r2);
          tq_r[i]  <= {q_in[T_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o = vld_r[T_BITS-1];
  assign geo_o = geo_r[T_BITS-1];
  assign tq_o  = tq_r[T_BITS-1];
endmodule
`default_nettype wire

>>> rtl/core/psd_err.sv
// ----------------------------------------------------------------------------
// psd_err
// closest point offset, error vector and squared distance
// ----------------------------------------------------------------------------
`default_nettype none
module psd_err (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire psd_pkg::geo_t                geo_i,
  input  wire logic [psd_pkg::T_BITS-1:0]   tq_i,
  output logic                              vld_o,
  output logic [psd_pkg::D2_W-1:0]          d2_o
);
  import psd_pkg::*;

  logic [3:0] vld_r;
  geo_t geo_r;
  logic [P_W-1:0] ppx_r, ppy_r;
  logic signed [E_W-1:0] ex_r, ey_r;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic [D2_W-1:0] d2_r;
  logic [P_W:0] rndx, rndy;
  logic [MAG_W-1:0] offx, offy;
  logic signed [E_W-1:0] rxe, rye, dxe, dye, sox, soy, ex_nxt, ey_nxt;

  always_comb begin
    rndx = (P_W+1)'(ppx_r) + ((P_W+1)'(1) << (T_BITS - 1));
    rndy = (P_W+1)'(ppy_r) + ((P_W+1)'(1) << (T_BITS - 1));
    offx = rndx[T_BITS +: MAG_W];
    offy = rndy[T_BITS +: MAG_W];
    rxe  = E_W'(geo_r.rx);
    rye  = E_W'(geo_r.ry);
    dxe  = E_W'(geo_r.dx);
    dye  = E_W'(geo_r.dy);
    sox  = geo_r.dx[DIFF_W-1] ? -$signed(E_W'(offx)) : $signed(E_W'(offx));
    soy  = geo_r.dy[DIFF_W-1] ? -$signed(E_W'(offy)) : $signed(E_W'(offy));
    case (geo_r.mode)
      MODE_END: begin
        ex_nxt = rxe - dxe;
        ey_nxt = rye - dye;
      end
      MODE_INTERIOR: begin
        ex_nxt = rxe - sox;
        ey_nxt = rye - soy;
      end
      default: begin
        ex_nxt = rxe;
        ey_nxt = rye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r <= geo_i;
      ppx_r <= P_W'(tq_i) * P_W'(mag_d(geo_i.dx));
      ppy_r <= P_W'(tq_i) * P_W'(mag_d(geo_i.dy));
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
      sqx_r <= SQ_W'(mag_e(ex_r)) * SQ_W'(mag_e(ex_r));
      sqy_r <= SQ_W'(mag_e(ey_r)) * SQ_W'(mag_e(ey_r));
      d2_r  <= D2_W'(sqx_r) + D2_W'(sqy_r);
    end
  end

  assign vld_o = vld_r[3];
  assign d2_o  = d2_r;
endmodule
`default_nettype wire

>>> rtl/core/psd_isqrt.sv
// ----------------------------------------------------------------------------
// psd_isqrt
// digit-by-digit integer square root, one root bit per stage, rounded down
// ----------------------------------------------------------------------------
`default_nettype none
module psd_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [psd_pkg::D2_W-1:0]     d2_i,
  output logic                              vld_o,
  output logic [psd_pkg::RT_W-1:0]          root_o
);
  import psd_pkg::*;

  logic [RT_W-1:0] vld_r;
  logic [SR_W-1:0] n_r   [RT_W];
  logic [RR_W-1:0] rem_r [RT_W];
  logic [RT_W-1:0] rt_r  [RT_W];

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    logic            v_in;
    logic [SR_W-1:0] n_in;
    logic [RR_W-1:0] r_in, r_sh, trial;
    logic [RT_W-1:0] q_in;

    if (i == 0) begin : g_first
      assign v_in = vld_i;
      assign n_in = SR_W'(d2_i);
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign n_in = n_r[i-1];
      assign r_in = rem_r[i-1];
      assign q_in = rt_r[i-1];
    end

    assign r_sh  = {r_in[RR_W-3:0], n_in[SR_W-1 -: 2]};
    assign trial = {q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= {n_in[SR_W-3:0], 2'b00};
        if (r_sh >= trial) begin
          rem_r[i] <= r_sh - trial;
          rt_r[i]  <= {q_in[RT_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= r_sh;
          rt_r[i]  <= {q_in[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_r[RT_W-1];
  assign root_o = rt_r[RT_W-1];
endmodule
`default_nettype wire

>>> rtl/core/point_segment_distance_2d_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_2d_unit
// distance from a 2d point to a segment, signed Q7.16 in, unsigned Q9.16 out
//
//   channel  signals                                   direction
//   in       in_valid in_ready in_point_* in_start_*    request in
//            in_end_*
//   out      out_valid out_ready out_distance           request out
//
// one request enters every cycle while the output is not stalled; the pipeline has
// 4 setup, 32 divider, 4 error and 27 square root stages
// synchronous reset clears only the stage valid bits
// a stall at the output freezes the whole pipeline; nothing is lost
// ----------------------------------------------------------------------------
`default_nettype none
module point_segment_distance_2d_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_point_x,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_point_y,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_start_x,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_start_y,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_end_x,
  input  wire logic [psd_pkg::COORD_W-1:0]  in_end_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [psd_pkg::OUT_W-1:0]         out_distance
);
  import psd_pkg::*;

  logic en;
  logic v1, v2, v3, v4;
  geo_t g1, g2;
  logic [LSQ_W-1:0] dot1, len1;
  logic [T_BITS-1:0] tq2;
  logic [D2_W-1:0] d2;
  logic [RT_W-1:0] root;

  assign en       = !v4 || out_ready;
  assign in_ready = en;

  psd_prep u_prep (
    .clk, .rst_n, .en, .vld_i(in_valid && en),
    .px(in_point_x), .py(in_point_y), .ax(in_start_x), .ay(in_start_y),
    .bx(in_end_x), .by(in_end_y),
    .vld_o(v1), .geo_o(g1), .dot_o(dot1), .len_o(len1)
  );

  psd_div u_div (
    .clk, .rst_n, .en, .vld_i(v1), .geo_i(g1), .dot_i(dot1), .len_i(len1),
    .vld_o(v2), .geo_o(g2), .tq_o(tq2)
  );

  psd_err u_err (
    .clk, .rst_n, .en, .vld_i(v2), .geo_i(g2), .tq_i(tq2),
    .vld_o(v3), .d2_o(d2)
  );

  psd_isqrt u_sqrt (
    .clk, .rst_n, .en, .vld_i(v3), .d2_i(d2),
    .vld_o(v4), .root_o(root)
  );

  assign out_valid    = v4;
  assign out_distance = root[OUT_W-1:0];

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");
  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance))
    else $error("result changed during stall");
  a_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= OUT_W'(23726567))
    else $error("distance out of range");
endmodule
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the point to segment distance unit against a bit-exact predictor;
// directed corner requests then random geometry under varied idling
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import psd_pkg::*;

  class distance_board;
    logic [OUT_W-1:0] pending[$];
    int errors;
    int checked;

    function automatic longint sx(logic [COORD_W-1:0] v);
      return longint'(signed'(v));
    endfunction

    function automatic longint unsigned absv(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint offset(longint unsigned tq, longint d);
      longint unsigned p;
      longint unsigned r;
      p = tq * absv(d);
      r = (p + (64'd1 << (T_BITS - 1))) >> T_BITS;
      return d < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [OUT_W-1:0] distance(logic [COORD_W-1:0] px_i,
        logic [COORD_W-1:0] py_i, logic [COORD_W-1:0] ax_i, logic [COORD_W-1:0] ay_i,
        logic [COORD_W-1:0] bx_i, logic [COORD_W-1:0] by_i);
      longint px, py, ax, ay, bx, by, dx, dy, rx, ry, cx, cy, ex, ey;
      longint unsigned lsq, pos, neg, dot, rem, tq, d2;
      px = sx(px_i); py = sx(py_i); ax = sx(ax_i); ay = sx(ay_i);
      bx = sx(bx_i); by = sx(by_i);
      dx = bx - ax; dy = by - ay; rx = px - ax; ry = py - ay;
      lsq = absv(dx) * absv(dx) + absv(dy) * absv(dy);
      pos = 0; neg = 0; cx = ax; cy = ay;
      if ((rx < 0) == (dx < 0)) pos += absv(rx) * absv(dx);
      else neg += absv(rx) * absv(dx);
      if ((ry < 0) == (dy < 0)) pos += absv(ry) * absv(dy);
      else neg += absv(ry) * absv(dy);
      if (lsq > TINY_LSQ && pos > neg) begin
        dot = pos - neg;
        if (dot >= lsq) begin
          cx = bx; cy = by;
        end else begin
          rem = dot; tq = 0;
          for (int i = 0; i < T_BITS; i++) begin
            rem = rem << 1; tq = tq << 1;
            if (rem >= lsq) begin
              rem -= lsq; tq |= 1;
            end
          end
          cx = ax + offset(tq, dx);
          cy = ay + offset(tq, dy);
        end
      end
      ex = px - cx; ey = py - cy;
      d2 = absv(ex) * absv(ex) + absv(ey) * absv(ey);
      return OUT_W'(root_floor(d2));
    endfunction

    function void note_request(logic [COORD_W-1:0] c[6]);
      pending.push_back(distance(c[0], c[1], c[2], c[3], c[4], c[5]));
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      checked++;
      if (pending.size() == 0) begin
        $error("distance: no request pending, got %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("distance: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [COORD_W-1:0] in_point_x = 0, in_point_y = 0, in_start_x = 0;
  logic [COORD_W-1:0] in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [OUT_W-1:0] out_distance;

  distance_board board = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  int quiet = 0;
  int sent = 0;

  always #6 clk = ~clk;

  point_segment_distance_2d_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance(out_distance)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_distance);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [COORD_W-1:0] rand_coord(int kind);
    case (kind)
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(63)) - 24'd32;
      2: return 24'h7fffff - COORD_W'($urandom_range(3));
      3: return 24'h800000 + COORD_W'($urandom_range(3));
      default: return COORD_W'(signed'(COORD_W'($urandom)) >>> $urandom_range(20));
    endcase
  endfunction

  task automatic send(logic [COORD_W-1:0] c[6]);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_point_x <= c[0]; in_point_y <= c[1]; in_start_x <= c[2];
    in_start_y <= c[3]; in_end_x <= c[4]; in_end_y <= c[5];
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(c);
    sent++;
  endtask

  task automatic random_phase(int n);
    logic [COORD_W-1:0] c[6];
    int k;
    repeat (n) begin
      k = $urandom_range(9);
      foreach (c[i]) c[i] = rand_coord(k < 5 ? 0 : (k < 7 ? 4 : $urandom_range(4)));
      if ($urandom_range(9) == 0) begin
        c[4] = c[2]; c[5] = c[3];
      end
      send(c);
    end
  endtask

  initial begin
    logic [COORD_W-1:0] c[6];
    logic [COORD_W-1:0] mx, mn;
    mx = 24'h7fffff; mn = 24'h800000;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // corners, degenerate segment, projection before start, past end, interior
    c = '{0, 0, 0, 0, 0, 0}; send(c);
    c = '{mx, mx, mn, mn, mn, mn}; send(c);
    c = '{mn, mn, mx, mx, mx, mx}; send(c);
    c = '{mx, mn, mn, mx, mx, mn}; send(c);
    c = '{mn, mx, mn, mn, mx, mx}; send(c);
    c = '{mx, mx, mn, mn, mx, mx}; send(c);
    c = '{mn, mx, mx, mn, mn, mx}; send(c);
    c = '{24'h10000, 24'h10000, 0, 0, 0, 0}; send(c);
    c = '{-24'sh10000, 0, 0, 0, 24'h10000, 0}; send(c);
    c = '{24'h30000, 24'h10000, 0, 0, 24'h20000, 0}; send(c);
    c = '{24'h10000, 24'h10000, 0, 0, 24'h20000, 0}; send(c);
    c = '{24'h20000, 24'h10000, 0, 0, 24'h20000, 0}; send(c);
    c = '{1, 1, 0, 0, 1, 0}; send(c);
    c = '{1, 1, 0, 0, 3, 3}; send(c);
    c = '{24'hffffff, 24'h000001, 24'h555555, 24'haaaaaa, 24'h123456, 24'hfedcba};
    send(c);
    c = '{24'h2aaaaa, 24'hd55555, 24'hffffff, 24'hffffff, 0, 24'h000001}; send(c);
    random_phase(280);
    send_idle = 56; random_phase(230);
    send_idle = 0; recv_stall = 56; random_phase(230);
    send_idle = 34; recv_stall = 34; random_phase(230);
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(230);
    join
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d requests, checked %0d distances across idle and stall phases",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
